/* rtl/core/iocr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iocr_pkg
// Shared widths, codes and types of the in-order commit ring.
// ----------------------------------------------------------------------------
package iocr_pkg;

  localparam int unsigned SeqW  = 63;
  localparam int unsigned GrpW  = 16;
  localparam int unsigned VerW  = 63;
  localparam int unsigned StatW = 2;
  localparam int unsigned PendW = 11;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_RETIRE = 1'b1;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_BEHIND   = 2'd1,
    ST_WIN_FULL = 2'd2,
    ST_OCCUPIED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CALC  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_e;

  // one ring slot as held in memory
  typedef struct packed {
    logic            full;
    logic [SeqW-1:0] seq;
    logic [GrpW-1:0] grp;
    logic [VerW-1:0] ver;
  } slot_t;

endpackage
`default_nettype wire

/* rtl/core/iocr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iocr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module iocr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/iocr_rem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iocr_rem
// Remainder of a sequence number by the ring depth, four-stage pipeline.
// ----------------------------------------------------------------------------
module iocr_rem #(
  parameter int unsigned Depth = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [iocr_pkg::SeqW-1:0]       value_i,
  output      logic                            busy_o,
  output      logic                            done_o,
  output      logic [$clog2(Depth)-1:0]        rem_o
);

  import iocr_pkg::*;

  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned PartW = 16;
  localparam int unsigned ProdW = PartW + IdxW;
  localparam int unsigned SumW  = 32;

  // weights of the upper 16-bit parts, 2^(16*k) mod depth
  localparam logic [IdxW-1:0] Wt1 = IdxW'((64'd1 << 16) % 64'(Depth));
  localparam logic [IdxW-1:0] Wt2 = IdxW'((64'd1 << 32) % 64'(Depth));
  localparam logic [IdxW-1:0] Wt3 = IdxW'((64'd1 << 48) % 64'(Depth));
  // floor(2^32 / depth), quotient estimate comes out low by at most one
  localparam logic [SumW-1:0] Recip = SumW'((64'd1 << 32) / 64'(Depth));

  logic [ProdW-1:0]  p0_q, p1_q, p2_q, p3_q;
  logic [SumW-1:0]   sum_q;
  logic [IdxW:0]     low_q;
  logic [IdxW:0]     quo_q;
  logic [IdxW-1:0]   rem_q;
  logic              v1_q, v2_q, v3_q;
  logic              done_q;
  logic [2*SumW-1:0] quo_prod;
  logic [IdxW:0]     rem_wide;

  // the sum of weighted parts stays below 2^32 for any depth up to 16384
  assign quo_prod = {{SumW{1'b0}}, sum_q} * {{SumW{1'b0}}, Recip};

  // remainder fits in IdxW+1 bits, so only low bits of the quotient matter
  always_comb begin
    rem_wide = low_q - quo_q * (IdxW+1)'(Depth);
    if (rem_wide >= (IdxW+1)'(Depth)) begin
      rem_wide = rem_wide - (IdxW+1)'(Depth);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p0_q <= ProdW'(value_i[15:0]);
      p1_q <= ProdW'(value_i[31:16]) * ProdW'(Wt1);
      p2_q <= ProdW'(value_i[47:32]) * ProdW'(Wt2);
      p3_q <= ProdW'(value_i[SeqW-1:48]) * ProdW'(Wt3);
    end
    if (v1_q) begin
      sum_q <= SumW'(p0_q) + SumW'(p1_q) + SumW'(p2_q) + SumW'(p3_q);
    end
    if (v2_q) begin
      quo_q <= quo_prod[SumW +: IdxW+1];
      low_q <= sum_q[IdxW:0];
    end
    if (v3_q) begin
      rem_q <= rem_wide[IdxW-1:0];
    end
  end

  assign busy_o = v1_q || v2_q || v3_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

/* rtl/core/in_order_commit_ring.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// in_order_commit_ring
// Reorder ring: entries are added out of order and retired in sequence order.
// ----------------------------------------------------------------------------
// After reset the block is busy while it clears every slot of the ring
// memory. Each transaction (add or retire tick) passes through acceptance in
// S_IDLE, the synchronous slot read in S_CALC, and the decision and write-back
// in S_EXEC; the result appears in the following cycle on the result ports for
// exactly one cycle with done_o high, and a new transaction may be started in
// that same cycle. The receiver cannot stall. A configuration write while the
// ring is empty reloads the head and keeps the block busy while the remainder
// pipeline finds the head's slot index.
// ----------------------------------------------------------------------------
module in_order_commit_ring #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic                        func_i,
  input  wire logic [iocr_pkg::GrpW-1:0]   group_id_i,
  input  wire logic [iocr_pkg::VerW-1:0]   data_version_i,
  input  wire logic [iocr_pkg::SeqW-1:0]   seq_num_i,
  output      logic                        done_o,
  output      logic [iocr_pkg::StatW-1:0]  status_o,
  output      logic                        retired_valid_o,
  output      logic [iocr_pkg::GrpW-1:0]   retired_group_o,
  output      logic [iocr_pkg::VerW-1:0]   retired_version_o,
  output      logic [iocr_pkg::SeqW-1:0]   retired_seq_o,
  output      logic                        needs_wait_o,
  output      logic [iocr_pkg::PendW-1:0]  pending_out_o,
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [iocr_pkg::SeqW-1:0]   cfg_data_i
);

  import iocr_pkg::*;

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam int unsigned EntW = $bits(slot_t);

  state_e          state_d, state_q;
  logic [IdxW-1:0] clr_q;
  logic [SeqW-1:0] head_d, head_q;
  logic [IdxW-1:0] hidx_d, hidx_q;
  logic [CntW-1:0] cnt_d, cnt_q;

  // transaction being worked on
  logic            func_q;
  logic [GrpW-1:0] grp_q;
  logic [VerW-1:0] ver_q;
  logic [SeqW-1:0] sn_q;
  status_e         chk_q;
  logic [IdxW-1:0] idx_q;

  // result registers
  logic            done_q;
  status_e         stat_q;
  logic            rv_q;
  logic [GrpW-1:0] rgrp_q;
  logic [VerW-1:0] rver_q;
  logic [SeqW-1:0] rseq_q;
  logic            nw_q;

  logic            accept;
  logic            cfg_fire;
  logic            rem_start;
  logic            rem_busy;
  logic            rem_done;
  logic [IdxW-1:0] rem_val;
  logic [SeqW-1:0] cfg_head;

  // slot memory ports
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  slot_t           ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [EntW-1:0] ram_rdata;
  slot_t           rd_slot;

  // window check of the incoming add, slot index of the incoming add or retire
  logic [SeqW-1:0] diff;
  logic [IdxW:0]   idx_sum;
  status_e         chk_d;
  logic [IdxW-1:0] idx_d;

  // write-back decision
  logic            hit;
  logic            add_ok;

  assign accept    = start && !busy;
  assign cfg_ready_o = !rem_busy && (state_q == S_IDLE || state_q == S_CLEAR);
  assign cfg_fire  = cfg_valid_i && cfg_ready_o;
  assign cfg_head  = cfg_data_i + SeqW'(1);
  assign rem_start = cfg_fire && (cnt_q == '0);
  assign busy      = (state_q != S_IDLE) || rem_busy;

  iocr_rem #(
    .Depth (RING_DEPTH)
  ) u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .value_i (cfg_head),
    .busy_o  (rem_busy),
    .done_o  (rem_done),
    .rem_o   (rem_val)
  );

  always_comb begin
    diff    = sn_q - head_q;
    idx_sum = {1'b0, hidx_q} + {1'b0, diff[IdxW-1:0]};
    if (idx_sum >= (IdxW+1)'(RING_DEPTH)) begin
      idx_sum = idx_sum - (IdxW+1)'(RING_DEPTH);
    end
    if (sn_q < head_q) begin
      chk_d = ST_BEHIND;
    end else if (diff >= SeqW'(RING_DEPTH)) begin
      chk_d = ST_WIN_FULL;
    end else begin
      chk_d = ST_OK;
    end
    idx_d = (func_q == FUNC_RETIRE) ? hidx_q : idx_sum[IdxW-1:0];
  end

  assign ram_re    = (state_q == S_CALC);
  assign ram_raddr = idx_d;
  assign rd_slot   = slot_t'(ram_rdata);

  assign hit    = (func_q == FUNC_RETIRE) && (cnt_q != '0) && rd_slot.full &&
                  (rd_slot.seq == head_q);
  assign add_ok = (func_q == FUNC_ADD) && (chk_q == ST_OK) && !rd_slot.full;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
    end else if (state_q == S_EXEC) begin
      if (add_ok) begin
        ram_we         = 1'b1;
        ram_wdata.full = 1'b1;
        ram_wdata.seq  = sn_q;
        ram_wdata.grp  = grp_q;
        ram_wdata.ver  = ver_q;
      end else if (hit) begin
        // retired slot goes back to empty
        ram_we = 1'b1;
      end
    end
  end

  iocr_ram #(
    .Width (EntW),
    .Depth (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    hidx_d  = hidx_q;
    cnt_d   = cnt_q;
    if (cfg_fire && (cnt_q == '0)) begin
      head_d = cfg_head;
    end
    if (rem_done) begin
      hidx_d = rem_val;
    end
    case (state_q)
      S_CLEAR: begin
        if (clr_q == IdxW'(RING_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (add_ok) begin
          cnt_d = cnt_q + CntW'(1);
        end else if (hit) begin
          cnt_d  = cnt_q - CntW'(1);
          head_d = head_q + SeqW'(1);
          // head wrapping past the top of the sequence space lands on slot zero
          hidx_d = (hidx_q == IdxW'(RING_DEPTH - 1) || head_q == '1) ?
                   '0 : hidx_q + IdxW'(1);
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      head_q  <= SeqW'(1);
      hidx_q  <= IdxW'(1);
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      hidx_q  <= hidx_d;
      cnt_q   <= cnt_d;
      done_q  <= (state_q == S_EXEC);
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      grp_q  <= group_id_i;
      ver_q  <= data_version_i;
      sn_q   <= seq_num_i;
    end
    if (state_q == S_CALC) begin
      chk_q <= chk_d;
      idx_q <= idx_d;
    end
    if (state_q == S_EXEC) begin
      if (func_q == FUNC_ADD) begin
        stat_q <= (chk_q == ST_OK && rd_slot.full) ? ST_OCCUPIED : chk_q;
      end else begin
        stat_q <= ST_OK;
      end
      rv_q   <= hit;
      rgrp_q <= hit ? rd_slot.grp : '0;
      rver_q <= hit ? rd_slot.ver : '0;
      rseq_q <= hit ? rd_slot.seq : '0;
      nw_q   <= hit && (rd_slot.grp != '0) && (rd_slot.ver != '0);
    end
  end

  assign done_o            = done_q;
  assign status_o          = stat_q;
  assign retired_valid_o   = rv_q;
  assign retired_group_o   = rgrp_q;
  assign retired_version_o = rver_q;
  assign retired_seq_o     = rseq_q;
  assign needs_wait_o      = nw_q;
  assign pending_out_o     = PendW'(cnt_q);

`ifndef NO_ASSERTIONS
  a_done_after_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_EXEC))
    else $error("result strobe without a preceding update cycle");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RING_DEPTH))
    else $error("pending count exceeds ring depth");

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_busy |-> (state_q == S_IDLE || state_q == S_CLEAR))
    else $error("head index search overlaps a transaction");

  a_head_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && retired_valid_o) |-> (head_q == retired_seq_o + SeqW'(1)))
    else $error("head did not advance past the retired entry");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for in_order_commit_ring. A shadow ring predicts the
// status, retired entry and pending count of every add and retire tick; a
// directed pass covers refusals, retire flags, the start register and the
// sequence wrap, then random phases run windowed traffic under several
// start sequences.
// ----------------------------------------------------------------------------
module testbench;
  import iocr_pkg::*;

  localparam int unsigned RingDepth  = 1024;
  localparam int unsigned StallLimit = 4000;
  localparam logic [SeqW-1:0] SeqMax = {SeqW{1'b1}};

  typedef struct {
    status_e         status;
    logic            retired;
    logic [GrpW-1:0] grp;
    logic [VerW-1:0] ver;
    logic [SeqW-1:0] seq;
    logic            needs_wait;
    logic [PendW-1:0] pending;
  } commit_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              func_i;
  logic [GrpW-1:0]   group_id_i;
  logic [VerW-1:0]   data_version_i;
  logic [SeqW-1:0]   seq_num_i;
  logic              done_o;
  logic [StatW-1:0]  status_o;
  logic              retired_valid_o;
  logic [GrpW-1:0]   retired_group_o;
  logic [VerW-1:0]   retired_version_o;
  logic [SeqW-1:0]   retired_seq_o;
  logic              needs_wait_o;
  logic [PendW-1:0]  pending_out_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [SeqW-1:0]   cfg_data_i;

  in_order_commit_ring #(
    .RING_DEPTH(RingDepth)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .group_id_i       (group_id_i),
    .data_version_i   (data_version_i),
    .seq_num_i        (seq_num_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .retired_valid_o  (retired_valid_o),
    .retired_group_o  (retired_group_o),
    .retired_version_o(retired_version_o),
    .retired_seq_o    (retired_seq_o),
    .needs_wait_o     (needs_wait_o),
    .pending_out_o    (pending_out_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // shadow copy of the ring
  logic            ring_full [RingDepth];
  logic [SeqW-1:0] ring_seq  [RingDepth];
  logic [GrpW-1:0] ring_grp  [RingDepth];
  logic [VerW-1:0] ring_ver  [RingDepth];
  logic [SeqW-1:0] head_seq;
  logic [SeqW-1:0] start_seq;
  int unsigned     held_cnt;

  commit_result_t  ring_results_q[$];
  int unsigned     mismatches;
  int unsigned     stall_cycles;
  int unsigned     idle_pct;
  bit              quiet;

  function automatic logic [SeqW-1:0] rand_seq();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[SeqW-1:0];
  endfunction

  function automatic logic [GrpW-1:0] rand_grp();
    logic [31:0] r;
    r = $urandom;
    return ($urandom_range(4, 0) == 0) ? '0 : r[GrpW-1:0];
  endfunction

  function automatic logic [VerW-1:0] rand_ver();
    return ($urandom_range(4, 0) == 0) ? '0 : rand_seq();
  endfunction

  function automatic logic [SeqW-1:0] rand_start();
    logic [SeqW-1:0] v;
    v = rand_seq();
    return (v == SeqMax) ? v - 1'b1 : v;
  endfunction

  function automatic void ring_clear();
    for (int i = 0; i < RingDepth; i++) begin
      ring_full[i] = 1'b0;
      ring_seq[i]  = '0;
      ring_grp[i]  = '0;
      ring_ver[i]  = '0;
    end
    start_seq = '0;
    head_seq  = SeqW'(1);
    held_cnt  = 0;
  endfunction

  function automatic commit_result_t commit_step(input logic fn, input logic [GrpW-1:0] grp,
                                                 input logic [VerW-1:0] ver,
                                                 input logic [SeqW-1:0] sn);
    commit_result_t r;
    int unsigned idx;
    r = '{status: ST_OK, retired: 1'b0, grp: '0, ver: '0, seq: '0, needs_wait: 1'b0,
          pending: '0};
    if (fn == FUNC_ADD) begin
      idx = 32'(sn % RingDepth);
      if (sn < head_seq) begin
        r.status = ST_BEHIND;
      end else if (sn - head_seq >= RingDepth) begin
        r.status = ST_WIN_FULL;
      end else if (ring_full[idx]) begin
        r.status = ST_OCCUPIED;
      end else begin
        ring_full[idx] = 1'b1;
        ring_seq[idx]  = sn;
        ring_grp[idx]  = grp;
        ring_ver[idx]  = ver;
        held_cnt++;
      end
    end else begin
      idx = 32'(head_seq % RingDepth);
      if (held_cnt > 0 && ring_full[idx] && ring_seq[idx] == head_seq) begin
        r.retired    = 1'b1;
        r.grp        = ring_grp[idx];
        r.ver        = ring_ver[idx];
        r.seq        = ring_seq[idx];
        r.needs_wait = (ring_grp[idx] != '0) && (ring_ver[idx] != '0);
        ring_full[idx] = 1'b0;
        ring_seq[idx]  = '0;
        ring_grp[idx]  = '0;
        ring_ver[idx]  = '0;
        head_seq = head_seq + 1'b1;
        held_cnt--;
      end
    end
    r.pending = PendW'(held_cnt);
    return r;
  endfunction

  task automatic send_item(input logic fn, input logic [GrpW-1:0] grp,
                           input logic [VerW-1:0] ver, input logic [SeqW-1:0] sn);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(99, 0) < idle_pct) gap = $urandom_range(12, 1);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start          <= 1'b1;
    func_i         <= fn;
    group_id_i     <= grp;
    data_version_i <= ver;
    seq_num_i      <= sn;
    do @(posedge clk_i); while (busy);
    ring_results_q.push_back(commit_step(fn, grp, ver, sn));
  endtask

  task automatic add_entry(input logic [GrpW-1:0] grp, input logic [VerW-1:0] ver,
                           input logic [SeqW-1:0] sn);
    send_item(FUNC_ADD, grp, ver, sn);
  endtask

  // payload fields carry noise, the block must ignore them
  task automatic retire_tick();
    send_item(FUNC_RETIRE, rand_grp(), rand_ver(), rand_seq());
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (ring_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_start_seq(input logic [SeqW-1:0] v);
    wait_results();
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    start_seq = v;
    if (held_cnt == 0) head_seq = v + 1'b1;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // fill gaps at the head and retire until the ring is empty
  task automatic drain_ring();
    while (held_cnt != 0) begin
      if (ring_full[head_seq % RingDepth]) retire_tick();
      else add_entry(rand_grp(), rand_ver(), head_seq);
    end
  endtask

  task automatic random_item(input int unsigned window, input int unsigned add_pct);
    int unsigned r;
    int unsigned offs;
    r = $urandom_range(99, 0);
    if (window == RingDepth && $urandom_range(7, 0) == 0) offs = RingDepth - 1;
    else offs = $urandom_range(window - 1, 0);
    if (r < add_pct) add_entry(rand_grp(), rand_ver(), head_seq + offs);
    else if (r < 90) retire_tick();
    else if (r < 93) add_entry(rand_grp(), rand_ver(), head_seq - 1 - $urandom_range(40, 0));
    else if (r < 96) add_entry(rand_grp(), rand_ver(),
                               head_seq + RingDepth + $urandom_range(200, 0));
    else add_entry(rand_grp(), rand_ver(), rand_seq());
  endtask

  task automatic test_refusals_after_reset();
    retire_tick();
    add_entry(16'h1234, 63'd7, '0);
    add_entry(16'h1234, 63'd7, SeqW'(RingDepth + 1));
    add_entry(16'h1234, 63'd7, SeqMax);
    add_entry('1, SeqMax, SeqW'(1));
    add_entry(16'h0001, 63'd1, SeqW'(1));
  endtask

  task automatic test_retire_flags();
    retire_tick();
    retire_tick();
    add_entry(16'h8001, '0, SeqW'(2));
    retire_tick();
    add_entry('0, {1'b1, 62'd0}, SeqW'(3));
    retire_tick();
  endtask

  task automatic test_cfg_hold_and_reload();
    add_entry(16'h0001, 63'd1, SeqW'(4));
    // ring not empty, head must stay put
    write_start_seq(63'd1000);
    add_entry(16'h00f0, 63'h55, SeqW'(5));
    retire_tick();
    retire_tick();
    write_start_seq(63'd1000);
    add_entry(16'h0f00, 63'haa, SeqW'(1001));
    retire_tick();
  endtask

  task automatic test_sequence_wrap();
    write_start_seq(SeqMax - 1'b1);
    add_entry(16'h00ff, 63'h1, SeqMax);
    add_entry(16'h00ff, 63'h2, '0);
    retire_tick();
    add_entry(16'h00ff, 63'h3, '0);
    retire_tick();
  endtask

  task automatic test_random_phases();
    logic [SeqW-1:0] starts[6];
    int unsigned window;
    starts[0] = '0;
    starts[1] = SeqMax - 1'b1;
    starts[2] = SeqMax - 21;
    starts[3] = rand_start();
    starts[4] = rand_start();
    starts[5] = 63'd1000;
    for (int p = 0; p < 6; p++) begin
      drain_ring();
      write_start_seq(starts[p]);
      case ($urandom_range(2, 0))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      window = (p % 3 == 0) ? 4 : ((p % 3 == 1) ? 16 : 64);
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(99, 0) == 0) wait_results();
        random_item(window, 50);
      end
    end
  endtask

  // full window: offset RingDepth-1 accepted, start register rewritten while entries held
  task automatic test_wide_window();
    drain_ring();
    write_start_seq(rand_start());
    idle_pct = 25;
    for (int i = 0; i < 230; i++) begin
      if (i == 100) write_start_seq(rand_start());
      if (i == 130) quiet = 1'b1;
      random_item(RingDepth, 65);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    commit_result_t want;
    if (rst_ni && done_o) begin
      if (ring_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no transaction pending at %0t", $time);
      end else begin
        want = ring_results_q.pop_front();
        check_field("status", want.status, status_o);
        check_field("retired_valid", want.retired, retired_valid_o);
        check_field("retired_group", want.grp, retired_group_o);
        check_field("retired_version", want.ver, retired_version_o);
        check_field("retired_seq", want.seq, retired_seq_o);
        check_field("needs_wait", want.needs_wait, needs_wait_o);
        check_field("pending_out", want.pending, pending_out_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    func_i         = FUNC_ADD;
    group_id_i     = '0;
    data_version_i = '0;
    seq_num_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    quiet          = 1'b0;
    idle_pct       = 0;
    mismatches     = 0;
    stall_cycles   = 0;
    ring_clear();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_refusals_after_reset();
    test_retire_flags();
    test_cfg_hold_and_reload();
    test_sequence_wrap();
    test_random_phases();
    test_wide_window();

    wait_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* in_order_commit_ring.f */
rtl/core/iocr_pkg.sv
rtl/core/iocr_ram.sv
rtl/core/iocr_rem.sv
rtl/core/in_order_commit_ring.sv
tb/testbench.sv
